// File: design/fsl_pkg.sv
package fsl_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned MaxFrames  = 64;

  localparam int unsigned SlotAw  = $clog2(StackDepth);
  localparam int unsigned SlotCw  = SlotAw + 1;
  localparam int unsigned FrameAw = $clog2(MaxFrames);
  localparam int unsigned FrameCw = FrameAw + 1;
  localparam int unsigned NameW   = 32;
  localparam int unsigned CmpW    = (SlotCw > 10) ? SlotCw : 10;

  localparam logic [NameW-1:0] NameUnnamed = '1;

  typedef enum logic [1:0] {
    CmdEnter  = 2'd0,
    CmdExit   = 2'd1,
    CmdLookup = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StOk         = 2'd0,
    StOverflow   = 2'd1,
    StNoFrame    = 2'd2,
    StFrameLimit = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SqIdle,
    SqDecode,
    SqFill,
    SqScan,
    SqExitWait,
    SqReply
  } seq_state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [31:0] lookup_name;
    logic [8:0]        param_slots;
    logic [8:0]        return_slots;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot_index;
    logic       created;
    logic [8:0] params_base;
    logic [8:0] returns_base;
  } out_t;

  typedef struct packed {
    logic              en;
    logic [SlotAw-1:0] addr;
    logic [NameW-1:0]  data;
  } name_wr_t;

  typedef struct packed {
    logic              en;
    logic [SlotAw-1:0] addr;
  } name_rd_t;

  typedef struct packed {
    logic               en;
    logic [FrameAw-1:0] addr;
    logic [SlotCw-1:0]  data;
  } base_wr_t;

  typedef struct packed {
    logic               en;
    logic [FrameAw-1:0] addr;
  } base_rd_t;

endpackage

// File: design/frame_stack_name_lookup_unit.sv
// channel | dir | handshake                  | payload
// in      | in  | in_valid_i / in_stall_o    | in_data_i  (fsl_pkg::in_t)
// out     | out | out_valid_o / out_stall_i  | out_data_o (fsl_pkg::out_t)
//
// one item at a time; stall stays high from transfer until its result is queued
// enter: one slot name written per cycle, marking each allocated slot unnamed
// lookup: one slot read from the name memory per cycle while scanning the top frame
// exit: one frame base memory read, when a frame remains below, to restore the top frame
// reset clears state, pending-read flag, slot and frame counts; memories need no clearing pass
// a stalled result waits in the output register while the next item is taken
module frame_stack_name_lookup_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fsl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fsl_pkg::out_t out_data_o
);

  logic          rsp_valid;
  logic          rsp_ready;
  fsl_pkg::out_t rsp;
  logic          out_valid_q, out_valid_d;
  fsl_pkg::out_t out_q;

  fsl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  assign rsp_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_valid && rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/fsl_name_ram.sv
module fsl_name_ram (
  input  logic                    clk_i,
  input  fsl_pkg::name_wr_t       wr_i,
  input  fsl_pkg::name_rd_t       rd_i,
  output logic [fsl_pkg::NameW-1:0] rdata_o
);

  logic [fsl_pkg::NameW-1:0] mem [fsl_pkg::StackDepth];
  logic [fsl_pkg::NameW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/fsl_base_ram.sv
module fsl_base_ram (
  input  logic                     clk_i,
  input  fsl_pkg::base_wr_t        wr_i,
  input  fsl_pkg::base_rd_t        rd_i,
  output logic [fsl_pkg::SlotCw-1:0] rdata_o
);

  logic [fsl_pkg::SlotCw-1:0] mem [fsl_pkg::MaxFrames];
  logic [fsl_pkg::SlotCw-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/fsl_seq.sv
module fsl_seq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  fsl_pkg::in_t in_data_i,
  output logic         rsp_valid_o,
  input  logic         rsp_ready_i,
  output fsl_pkg::out_t rsp_o
);

  localparam int unsigned SlotCw  = fsl_pkg::SlotCw;
  localparam int unsigned SlotAw  = fsl_pkg::SlotAw;
  localparam int unsigned FrameCw = fsl_pkg::FrameCw;
  localparam int unsigned FrameAw = fsl_pkg::FrameAw;
  localparam int unsigned CmpW    = fsl_pkg::CmpW;

  fsl_pkg::seq_state_e state_q, state_d;
  fsl_pkg::in_t        item_q, item_d;
  fsl_pkg::out_t       rsp_q, rsp_d;
  logic [SlotCw-1:0]   used_q, used_d;
  logic [FrameCw-1:0]  frames_q, frames_d;
  logic [SlotCw-1:0]   top_base_q, top_base_d;
  logic [SlotCw-1:0]   ptr_q, ptr_d;
  logic [SlotCw-1:0]   rd_idx_q, rd_idx_d;
  logic                rd_pend_q, rd_pend_d;

  fsl_pkg::name_wr_t   name_wr;
  fsl_pkg::name_rd_t   name_rd;
  fsl_pkg::base_wr_t   base_wr;
  fsl_pkg::base_rd_t   base_rd;
  logic [fsl_pkg::NameW-1:0] name_rdata;
  logic [SlotCw-1:0]   base_rdata;

  logic [9:0]          need;
  logic [SlotCw-1:0]   free_slots;
  logic                hit;

  fsl_name_ram u_name_ram (
    .clk_i  (clk_i),
    .wr_i   (name_wr),
    .rd_i   (name_rd),
    .rdata_o(name_rdata)
  );

  fsl_base_ram u_base_ram (
    .clk_i  (clk_i),
    .wr_i   (base_wr),
    .rd_i   (base_rd),
    .rdata_o(base_rdata)
  );

  assign need       = 10'(item_q.param_slots) + 10'(item_q.return_slots);
  assign free_slots = SlotCw'(fsl_pkg::StackDepth) - used_q;
  assign hit        = rd_pend_q && (name_rdata == item_q.lookup_name);

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    rsp_d      = rsp_q;
    used_d     = used_q;
    frames_d   = frames_q;
    top_base_d = top_base_q;
    ptr_d      = ptr_q;
    rd_idx_d   = rd_idx_q;
    rd_pend_d  = 1'b0;
    name_wr    = '0;
    name_rd    = '0;
    base_wr    = '0;
    base_rd    = '0;

    case (state_q)
      fsl_pkg::SqIdle: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = fsl_pkg::SqDecode;
        end
      end

      fsl_pkg::SqDecode: begin
        rsp_d   = '0;
        state_d = fsl_pkg::SqReply;
        case (item_q.command)
          fsl_pkg::CmdEnter: begin
            if (frames_q == FrameCw'(fsl_pkg::MaxFrames)) begin
              rsp_d.status = fsl_pkg::StFrameLimit;
            end else if (CmpW'(need) > CmpW'(free_slots)) begin
              rsp_d.status = fsl_pkg::StOverflow;
            end else begin
              base_wr.en   = 1'b1;
              base_wr.addr = frames_q[FrameAw-1:0];
              base_wr.data = used_q;
              frames_d     = frames_q + FrameCw'(1);
              top_base_d   = used_q;
              ptr_d        = used_q;
              used_d       = SlotCw'(CmpW'(used_q) + CmpW'(need));
              rsp_d.params_base  = 9'(used_q);
              rsp_d.returns_base = 9'(CmpW'(used_q) + CmpW'(item_q.param_slots));
              state_d      = fsl_pkg::SqFill;
            end
          end
          fsl_pkg::CmdExit: begin
            if (frames_q == '0) begin
              rsp_d.status = fsl_pkg::StNoFrame;
            end else begin
              frames_d = frames_q - FrameCw'(1);
              used_d   = top_base_q;
              if (frames_q >= FrameCw'(2)) begin
                base_rd.en   = 1'b1;
                base_rd.addr = FrameAw'(frames_q - FrameCw'(2));
                state_d      = fsl_pkg::SqExitWait;
              end
            end
          end
          fsl_pkg::CmdLookup: begin
            if (frames_q == '0) begin
              rsp_d.status = fsl_pkg::StNoFrame;
            end else begin
              ptr_d   = top_base_q;
              state_d = fsl_pkg::SqScan;
            end
          end
          default: begin
            rsp_d = '0;
          end
        endcase
      end

      fsl_pkg::SqFill: begin
        if (ptr_q == used_q) begin
          state_d = fsl_pkg::SqReply;
        end else begin
          name_wr.en   = 1'b1;
          name_wr.addr = ptr_q[SlotAw-1:0];
          name_wr.data = fsl_pkg::NameUnnamed;
          ptr_d        = ptr_q + SlotCw'(1);
        end
      end

      fsl_pkg::SqScan: begin
        if (hit) begin
          rsp_d.slot_index = 8'(rd_idx_q);
          state_d          = fsl_pkg::SqReply;
        end else if (ptr_q < used_q) begin
          name_rd.en   = 1'b1;
          name_rd.addr = ptr_q[SlotAw-1:0];
          rd_pend_d    = 1'b1;
          rd_idx_d     = ptr_q;
          ptr_d        = ptr_q + SlotCw'(1);
        end else begin
          if (used_q == SlotCw'(fsl_pkg::StackDepth)) begin
            rsp_d.status = fsl_pkg::StOverflow;
          end else begin
            name_wr.en       = 1'b1;
            name_wr.addr     = used_q[SlotAw-1:0];
            name_wr.data     = item_q.lookup_name;
            used_d           = used_q + SlotCw'(1);
            rsp_d.slot_index = 8'(used_q);
            rsp_d.created    = 1'b1;
          end
          state_d = fsl_pkg::SqReply;
        end
      end

      fsl_pkg::SqExitWait: begin
        top_base_d = base_rdata;
        state_d    = fsl_pkg::SqReply;
      end

      fsl_pkg::SqReply: begin
        if (rsp_ready_i) begin
          state_d = fsl_pkg::SqIdle;
        end
      end

      default: begin
        state_d = fsl_pkg::SqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fsl_pkg::SqIdle;
      used_q    <= '0;
      frames_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      frames_q  <= frames_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rsp_q      <= rsp_d;
    top_base_q <= top_base_d;
    ptr_q      <= ptr_d;
    rd_idx_q   <= rd_idx_d;
  end

  assign in_stall_o  = (state_q != fsl_pkg::SqIdle);
  assign rsp_valid_o = (state_q == fsl_pkg::SqReply);
  assign rsp_o       = rsp_q;

  a_frames_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q <= FrameCw'(fsl_pkg::MaxFrames))
    else $error("open frame count beyond limit");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SlotCw'(fsl_pkg::StackDepth))
    else $error("slot count beyond store depth");

  a_base_below_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frames_q != '0 && state_q == fsl_pkg::SqIdle) |-> top_base_q <= used_q)
    else $error("top frame base above slot count");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fsl_pkg::SqScan || state_q == fsl_pkg::SqFill) |-> ptr_q <= used_q)
    else $error("scan or fill pointer past slot count");

  a_reply_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> (rsp_valid_o && $stable(rsp_q)))
    else $error("pending result dropped or changed");

endmodule
